/* rtl/core/bba_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the buddy block allocator.
package bba_pkg;

    localparam int POOL_BYTES = 4096;
    localparam int MIN_BLOCK  = 64;
    localparam int NUM_UNITS  = POOL_BYTES / MIN_BLOCK;
    localparam int UNIT_W     = $clog2(NUM_UNITS);
    localparam int TOP_ORDER  = UNIT_W;
    localparam int ORD_W      = $clog2(TOP_ORDER + 1);
    localparam int LOG_MIN    = $clog2(MIN_BLOCK);

    localparam int ADDR_W = 12;
    localparam int REQ_W  = 13;
    localparam int STAT_W = 2;
    localparam int POOL_W = $clog2(POOL_BYTES) + 1;
    localparam int CMP_W  = (POOL_W > REQ_W) ? POOL_W : REQ_W;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_BLOCK = 2'd2;

    typedef struct packed {
        logic              op;
        logic [REQ_W-1:0]  request_size;
        logic [ADDR_W-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [STAT_W-1:0] status;
    } t_rsp;

    typedef struct packed {
        logic             head;
        logic             free;
        logic [ORD_W-1:0] order;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_SPLIT,
        S_F_RD,
        S_F_CHK,
        S_M_RD,
        S_M_CHK,
        S_M_LO,
        S_DONE
    } t_state;

    function automatic t_entry reset_entry(input logic [UNIT_W-1:0] unit);
        t_entry e;
        e.head  = (unit == '0);
        e.free  = 1'b1;
        e.order = (unit == '0) ? ORD_W'(TOP_ORDER) : '0;
        return e;
    endfunction

    function automatic logic [CMP_W-1:0] block_bytes(input logic [ORD_W-1:0] ord);
        return CMP_W'(MIN_BLOCK) << ord;
    endfunction

endpackage

/* rtl/core/buddy_block_allocator_core.sv */
`timescale 1ns / 1ps
// Top level of the buddy block allocator: sequencer, block table RAM and result register.
// Allocate: scans the blocks in address order and splits the first free one that fits down to
// the smallest size that still holds the request; no space when nothing fits or for size 0.
// Free: frees the block and merges it with its buddy while the buddy is a free block of the
// same order, up to the whole pool; refuses an unaligned offset or one starting no block.
// One request at a time, the next taken once the result loads; the synchronous active-low
// reset clears the table valid bits so the pool is one free block.
module buddy_block_allocator_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bba_pkg::t_req i_in_req,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bba_pkg::t_rsp o_out_res
);
    import bba_pkg::*;

    t_state r_state, n_state;
    logic [UNIT_W-1:0] r_unit, n_unit;
    logic [ORD_W-1:0]  r_ord, n_ord;
    logic [REQ_W-1:0]  r_size, n_size;
    logic [UNIT_W-1:0] r_bud, n_bud;
    logic [UNIT_W-1:0] r_rd_unit;
    logic [NUM_UNITS-1:0] r_valid;
    logic [ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic r_out_valid, n_out_valid;
    t_rsp r_out, n_out;

    logic              ram_we;
    logic [UNIT_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    logic [UNIT_W-1:0] ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;
    t_entry            rd_ent;

    logic [ORD_W-1:0]  cmp_ord;
    logic              cmp_fits;
    logic [UNIT_W:0]   scan_next;
    logic [ADDR_W-1:0] free_unit_ext;

    bba_ram #(
        .WIDTH(ENT_W),
        .DEPTH(NUM_UNITS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign rd_ent = r_valid[r_rd_unit] ? t_entry'(ram_rdata) : reset_entry(r_rd_unit);

    assign cmp_fits  = block_bytes(cmp_ord) >= CMP_W'(r_size);
    assign scan_next = {1'b0, r_unit} + ((UNIT_W + 1)'(1) << rd_ent.order);
    assign free_unit_ext = i_in_req.block_address >> LOG_MIN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_unit       <= n_unit;
        r_ord        <= n_ord;
        r_size       <= n_size;
        r_bud        <= n_bud;
        r_rd_unit    <= ram_raddr;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_unit       = r_unit;
        n_ord        = r_ord;
        n_size       = r_size;
        n_bud        = r_bud;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_waddr    = r_unit;
        ram_wdata    = rd_ent;
        ram_raddr    = r_unit;
        cmp_ord      = rd_ent.order;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_addr   = '0;
                    n_res_status = STAT_OK;
                    n_unit       = '0;
                    n_size       = i_in_req.request_size;
                    if (i_in_req.op == OP_ALLOC) begin
                        if (i_in_req.request_size == '0) begin
                            n_res_status = STAT_NO_SPACE;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end else begin
                        if (i_in_req.block_address[LOG_MIN-1:0] != '0 ||
                            free_unit_ext >= ADDR_W'(NUM_UNITS)) begin
                            n_res_status = STAT_NO_BLOCK;
                            n_state      = S_DONE;
                        end else begin
                            n_unit  = i_in_req.block_address[LOG_MIN +: UNIT_W];
                            n_state = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD: begin
                ram_raddr = r_unit;
                n_state   = S_A_CHK;
            end
            S_A_CHK: begin
                cmp_ord = rd_ent.order;
                if (rd_ent.free && cmp_fits) begin
                    n_ord   = rd_ent.order;
                    n_state = S_A_SPLIT;
                end else if (scan_next >= (UNIT_W + 1)'(NUM_UNITS)) begin
                    n_res_status = STAT_NO_SPACE;
                    n_state      = S_DONE;
                end else begin
                    n_unit  = scan_next[UNIT_W-1:0];
                    n_state = S_A_RD;
                end
            end
            S_A_SPLIT: begin
                cmp_ord = r_ord - ORD_W'(1);
                ram_we  = 1'b1;
                if (r_ord != '0 && cmp_fits) begin
                    n_ord           = r_ord - ORD_W'(1);
                    ram_waddr       = r_unit + (UNIT_W'(1) << (r_ord - ORD_W'(1)));
                    ram_wdata.head  = 1'b1;
                    ram_wdata.free  = 1'b1;
                    ram_wdata.order = r_ord - ORD_W'(1);
                end else begin
                    ram_waddr       = r_unit;
                    ram_wdata.head  = 1'b1;
                    ram_wdata.free  = 1'b0;
                    ram_wdata.order = r_ord;
                    n_res_addr      = ADDR_W'(r_unit) << LOG_MIN;
                    n_state         = S_DONE;
                end
            end
            S_F_RD: begin
                ram_raddr = r_unit;
                n_state   = S_F_CHK;
            end
            S_F_CHK: begin
                if (!rd_ent.head) begin
                    n_res_status = STAT_NO_BLOCK;
                    n_state      = S_DONE;
                end else begin
                    ram_we          = 1'b1;
                    ram_waddr       = r_unit;
                    ram_wdata.head  = 1'b1;
                    ram_wdata.free  = 1'b1;
                    ram_wdata.order = rd_ent.order;
                    n_ord           = rd_ent.order;
                    n_state         = S_M_RD;
                end
            end
            S_M_RD: begin
                if (r_ord >= ORD_W'(TOP_ORDER)) begin
                    n_state = S_DONE;
                end else begin
                    ram_raddr = r_unit ^ (UNIT_W'(1) << r_ord);
                    n_bud     = ram_raddr;
                    n_state   = S_M_CHK;
                end
            end
            S_M_CHK: begin
                if (rd_ent.head && rd_ent.free && rd_ent.order == r_ord) begin
                    ram_we          = 1'b1;
                    ram_waddr       = (r_unit < r_bud) ? r_bud : r_unit;
                    ram_wdata.head  = 1'b0;
                    ram_wdata.free  = 1'b1;
                    ram_wdata.order = '0;
                    n_unit          = (r_unit < r_bud) ? r_unit : r_bud;
                    n_state         = S_M_LO;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_M_LO: begin
                ram_we          = 1'b1;
                ram_waddr       = r_unit;
                ram_wdata.head  = 1'b1;
                ram_wdata.free  = 1'b1;
                ram_wdata.order = r_ord + ORD_W'(1);
                n_ord           = r_ord + ORD_W'(1);
                n_state         = S_M_RD;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out.address = r_res_addr;
                    n_out.status  = r_res_status;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

/* rtl/core/bba_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bba_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the buddy block allocator and its bind to the top level.
module bba_assertions (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input bba_pkg::t_req i_in_req,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input bba_pkg::t_rsp o_out_res
);
    import bba_pkg::*;

    logic unused_req;
    assign unused_req = ^i_in_req;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_res))
        else $error("Result changed or dropped while stalled.");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("A new request was taken while one is in progress.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_res.status == STAT_OK ||
                         o_out_res.status == STAT_NO_SPACE ||
                         o_out_res.status == STAT_NO_BLOCK))
        else $error("Result carries an undefined status.");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_res.status != STAT_OK |-> o_out_res.address == '0)
        else $error("Failed request returned a nonzero address.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("Block is not idle after reset.");

endmodule

bind buddy_block_allocator_core bba_assertions u_bba_assertions (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_req   (i_in_req),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_res  (o_out_res)
);

/* tb/sv/bba_checker.sv */
`timescale 1ns / 1ps
// Checker for the buddy block allocator: tracks the block table, predicts and compares responses.
module bba_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  bba_pkg::t_req i_in_req,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  bba_pkg::t_rsp i_out_res,
    output int            o_fail_count,
    output int            o_pending
);
    import bba_pkg::*;

    logic [ORD_W-1:0] tbl_order [NUM_UNITS];
    logic             tbl_head  [NUM_UNITS];
    logic             tbl_free  [NUM_UNITS];

    t_rsp rsp_expected [$];
    int   mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void clear_table();
        for (int u = 0; u < NUM_UNITS; u++) begin
            tbl_head[u]  = (u == 0);
            tbl_free[u]  = 1'b1;
            tbl_order[u] = (u == 0) ? ORD_W'(TOP_ORDER) : '0;
        end
    endfunction

    function automatic t_rsp apply_alloc(input logic [REQ_W-1:0] size);
        t_rsp r;
        int   u;
        int   ord;
        int   bud;
        r.address = '0;
        r.status  = STAT_NO_SPACE;
        if (size == '0) begin
            return r;
        end
        u = 0;
        while (u < NUM_UNITS) begin
            ord = int'(tbl_order[u]);
            if (tbl_free[u] && (MIN_BLOCK << ord) >= int'(size)) begin
                // Halve the block while the lower half still holds the request.
                while (ord > 0 && (MIN_BLOCK << (ord - 1)) >= int'(size)) begin
                    ord--;
                    bud = u + (1 << ord);
                    tbl_head[bud]  = 1'b1;
                    tbl_free[bud]  = 1'b1;
                    tbl_order[bud] = ORD_W'(ord);
                end
                tbl_order[u] = ORD_W'(ord);
                tbl_free[u]  = 1'b0;
                r.address    = ADDR_W'(u * MIN_BLOCK);
                r.status     = STAT_OK;
                return r;
            end
            u += 1 << ord;
        end
        return r;
    endfunction

    function automatic t_rsp apply_free(input logic [ADDR_W-1:0] addr);
        t_rsp r;
        int   u;
        int   k;
        int   bud;
        int   lo;
        int   hi;
        bit   merging;
        r.address = '0;
        r.status  = STAT_NO_BLOCK;
        if (int'(addr) % MIN_BLOCK != 0) begin
            return r;
        end
        u = int'(addr) / MIN_BLOCK;
        if (u >= NUM_UNITS || !tbl_head[u]) begin
            return r;
        end
        tbl_free[u] = 1'b1;
        k = int'(tbl_order[u]);
        merging = 1'b1;
        while (merging && k < TOP_ORDER) begin
            bud = u ^ (1 << k);
            if (tbl_head[bud] && tbl_free[bud] && int'(tbl_order[bud]) == k) begin
                lo = (u < bud) ? u : bud;
                hi = (u < bud) ? bud : u;
                tbl_head[hi]  = 1'b0;
                tbl_free[hi]  = 1'b1;
                tbl_order[hi] = '0;
                k++;
                tbl_order[lo] = ORD_W'(k);
                tbl_free[lo]  = 1'b1;
                u = lo;
            end else begin
                merging = 1'b0;
            end
        end
        r.status = STAT_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            clear_table();
            rsp_expected.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_in_req.op == OP_ALLOC) begin
                    rsp_expected.push_back(apply_alloc(i_in_req.request_size));
                end else begin
                    rsp_expected.push_back(apply_free(i_in_req.block_address));
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (rsp_expected.size() == 0) begin
                    report_mismatch($sformatf(
                        "response with no request pending (address %0d status %0d)",
                        i_out_res.address, i_out_res.status));
                end else begin
                    want = rsp_expected.pop_front();
                    if (i_out_res.address !== want.address) begin
                        report_mismatch($sformatf("address got %0d expected %0d",
                                                  i_out_res.address, want.address));
                    end
                    if (i_out_res.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  i_out_res.status, want.status));
                    end
                end
            end
        end
        o_pending = rsp_expected.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Top of the buddy block allocator testbench: clock, reset, request stimulus and verdict.
module testbench;
    import bba_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 275;

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_req in_req;
    logic out_valid;
    logic out_ready;
    t_rsp out_res;

    int fail_count;
    int pending;
    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int idle_cycles       = 0;

    logic              sent_ops    [$];
    logic [ADDR_W-1:0] live_blocks [$];
    logic [ADDR_W-1:0] last_freed  = '0;

    buddy_block_allocator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (out_res)
    );

    bba_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_res    (out_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk     = 1'b0;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_req    = '0;
        out_ready = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("buddy_block_allocator_core verification failed");
            $finish;
        end
    end

    // Successful allocations feed the pool of addresses that later frees draw from.
    always @(posedge i_clk) begin
        logic op;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                sent_ops.push_back(in_req.op);
            end
            if (out_valid && out_ready && sent_ops.size() > 0) begin
                op = sent_ops.pop_front();
                if (op == OP_ALLOC && out_res.status == STAT_OK) begin
                    live_blocks.push_back(out_res.address);
                end
            end
        end
    end

    function automatic t_req req_of(input logic op, input int size, input int addr);
        t_req r;
        r.op            = op;
        r.request_size  = REQ_W'(size);
        r.block_address = ADDR_W'(addr);
        return r;
    endfunction

    function automatic t_req make_random_req(input bit filling);
        t_req r;
        int   pick;
        int   idx;
        r.op            = OP_ALLOC;
        r.request_size  = REQ_W'($urandom);
        r.block_address = ADDR_W'($urandom);
        pick = $urandom_range(99);
        if (pick < (filling ? 70 : 30)) begin
            case ($urandom_range(19))
                0:       r.request_size = '0;
                1, 2:    r.request_size = REQ_W'(MIN_BLOCK << $urandom_range(TOP_ORDER));
                3, 4:    r.request_size = REQ_W'((MIN_BLOCK << $urandom_range(TOP_ORDER)) + 1);
                5:       r.request_size = REQ_W'($urandom_range(8191, POOL_BYTES + 1));
                6, 7, 8: r.request_size = REQ_W'($urandom_range(POOL_BYTES, 1));
                default: r.request_size = REQ_W'($urandom_range(512, 1));
            endcase
        end else begin
            r.op = OP_FREE;
            pick = $urandom_range(99);
            if (pick < 70 && live_blocks.size() > 0) begin
                idx = $urandom_range(live_blocks.size() - 1);
                r.block_address = live_blocks[idx];
                last_freed = live_blocks[idx];
                live_blocks.delete(idx);
            end else if (pick < 80) begin
                r.block_address = last_freed;
            end else if (pick < 92) begin
                r.block_address = ADDR_W'($urandom_range(NUM_UNITS - 1) * MIN_BLOCK);
            end
        end
        return r;
    endfunction

    task automatic send_req(input t_req r);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        bit filling;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(req_of(OP_ALLOC, 0, 0));
        send_req(req_of(OP_ALLOC, POOL_BYTES, 4095));
        send_req(req_of(OP_ALLOC, 1, 0));
        send_req(req_of(OP_FREE, 8191, 0));
        send_req(req_of(OP_FREE, 0, 0));
        send_req(req_of(OP_ALLOC, 8191, 0));
        send_req(req_of(OP_ALLOC, POOL_BYTES + 1, 0));
        send_req(req_of(OP_ALLOC, 1, 0));
        send_req(req_of(OP_ALLOC, MIN_BLOCK, 0));
        send_req(req_of(OP_ALLOC, MIN_BLOCK + 1, 0));
        send_req(req_of(OP_ALLOC, 2048, 0));
        send_req(req_of(OP_ALLOC, 1024, 0));
        send_req(req_of(OP_FREE, 0, 32));
        send_req(req_of(OP_FREE, 0, 4032));
        send_req(req_of(OP_FREE, 0, 4095));
        send_req(req_of(OP_FREE, 0, 2048));
        send_req(req_of(OP_FREE, 0, 1024));
        send_req(req_of(OP_FREE, 0, 64));
        send_req(req_of(OP_FREE, 0, 0));
        send_req(req_of(OP_FREE, 0, 128));
        send_req(req_of(OP_ALLOC, POOL_BYTES, 0));
        send_req(req_of(OP_FREE, 0, 0));
        send_req(req_of(OP_ALLOC, 2049, 0));
        send_req(req_of(OP_FREE, 0, 0));

        filling = 1'b1;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
                default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(29) == 0) begin
                    filling = !filling;
                end
                send_req(make_random_req(filling));
            end
        end
        in_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("buddy_block_allocator_core verification clean");
        end else begin
            $display("buddy_block_allocator_core verification failed");
        end
        $finish;
    end

endmodule
